// ===== rtl/core/ttbd_pkg.sv =====
`timescale 1ns / 1ps

package ttbd_pkg;

	// Width of the decoded byte counter and its saturation value.
	localparam int CountWidth = 16;
	localparam logic [CountWidth-1:0] CountMax = {CountWidth{1'b1}};

	// Results one character can cause: up to three bytes and one status.
	localparam int MaxBytes = 3;
	localparam int QueueDepth = 4;
	localparam int QueuePtrWidth = $clog2(QueueDepth);

	// Configuration register indexes.
	localparam logic [1:0] RegBaseMode = 2'd0;
	localparam logic [1:0] RegIgnoreBlanks = 2'd1;
	localparam logic [1:0] RegOutCapacity = 2'd2;

	// Encodings.
	localparam logic [1:0] ModeAuto = 2'd0;
	localparam logic [1:0] ModeHex = 2'd1;
	localparam logic [1:0] ModeB64 = 2'd2;
	localparam logic [1:0] ModeText = 2'd3;

	// Status codes.
	localparam logic [2:0] StOk = 3'd0;
	localparam logic [2:0] StShort = 3'd1;
	localparam logic [2:0] StNoPrefix = 3'd2;
	localparam logic [2:0] StBadPrefix = 3'd3;
	localparam logic [2:0] StBadChar = 3'd4;
	localparam logic [2:0] StBadPad = 3'd5;
	localparam logic [2:0] StTruncated = 3'd6;
	localparam logic [2:0] StNoData = 3'd7;

	// Result kinds.
	localparam logic KindData = 1'b0;
	localparam logic KindStatus = 1'b1;

	// Character codes.
	localparam logic [7:0] ChZero = 8'h30;
	localparam logic [7:0] ChUnder = 8'h5f;
	localparam logic [7:0] ChPad = 8'h3d;
	localparam logic [7:0] ChSpace = 8'h20;
	localparam logic [7:0] ChTab = 8'h09;
	localparam logic [7:0] ChPlus = 8'h2b;
	localparam logic [7:0] ChSlash = 8'h2f;

	typedef struct packed {
		logic [7:0] in_char;
		logic       in_last;
	} in_item_t;

	typedef struct packed {
		logic                  out_kind;
		logic [7:0]            out_byte;
		logic [2:0]            status;
		logic [CountWidth-1:0] byte_count;
		logic                  out_last;
	} out_item_t;

	typedef struct packed {
		logic [1:0]            base_mode;
		logic                  ignore_blanks;
		logic [CountWidth-1:0] out_capacity;
	} cfg_t;

	// One character's worth of results, as handed from front to back.
	typedef struct packed {
		logic [MaxBytes-1:0][7:0] bytes;
		logic [1:0]               n_data;
		logic [CountWidth-1:0]    base_count;
		logic                     has_status;
		logic [2:0]               status;
		logic [CountWidth-1:0]    status_count;
	} entry_t;

	// Hex digit value; bit 4 set when the character is a digit.
	function automatic logic [4:0] hex_lookup(input logic [7:0] c);
		logic [4:0] r;
		r = '0;
		if (c inside {[8'h30:8'h39]}) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c inside {[8'h61:8'h66]}) begin
			r = {1'b1, 4'(c - 8'h57)};
		end else if (c inside {[8'h41:8'h46]}) begin
			r = {1'b1, 4'(c - 8'h37)};
		end
		return r;
	endfunction

	// Base64 digit value; bit 6 set when the character is a digit.
	function automatic logic [6:0] b64_lookup(input logic [7:0] c);
		logic [6:0] r;
		r = '0;
		if (c inside {[8'h41:8'h5a]}) begin
			r = {1'b1, 6'(c - 8'h41)};
		end else if (c inside {[8'h61:8'h7a]}) begin
			r = {1'b1, 6'(c - 8'h47)};
		end else if (c inside {[8'h30:8'h39]}) begin
			r = {1'b1, 6'(c + 8'h04)};
		end else if (c == ChPlus) begin
			r = {1'b1, 6'd62};
		end else if (c == ChSlash) begin
			r = {1'b1, 6'd63};
		end
		return r;
	endfunction

endpackage

// ===== rtl/core/ttbd_front.sv =====
`timescale 1ns / 1ps

module ttbd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  ttbd_pkg::cfg_t    cfg,
	input  logic              push,
	input  ttbd_pkg::in_item_t in_data,
	input  logic              q_ready,
	output logic              q_valid,
	output ttbd_pkg::entry_t  q_entry,
	output logic              accept
);

	// Prefix phase codes.
	localparam logic [1:0] PhFirst = 2'd0;
	localparam logic [1:0] PhLetter = 2'd1;
	localparam logic [1:0] PhData = 2'd2;

	// Staged character kinds.
	localparam logic [1:0] KDigit = 2'd0;
	localparam logic [1:0] KPad = 2'd1;
	localparam logic [1:0] KBad = 2'd2;

	logic [1:0]                     phase_q, phase_d;
	logic [1:0]                     base_q, base_d;
	logic [1:0]                     pos_q, pos_d;
	logic [2:0][5:0]                bits_q, bits_d;
	logic [2:0][1:0]                kinds_q, kinds_d;
	logic                           open_q, open_d;
	logic                           seen_q, seen_d;
	logic                           uok_q, uok_d;
	logic [2:0]                     err_q, err_d;
	logic [ttbd_pkg::CountWidth-1:0] count_q, count_d;

	logic [7:0]                     c;
	logic                           last;
	logic [1:0]                     use_base;
	logic                           run_data;
	logic                           blank;
	logic                           skip;
	logic [1:0]                     p;
	logic [1:0]                     kind;
	logic [5:0]                     val;
	logic [4:0]                     hx;
	logic [6:0]                     bx;
	logic [1:0]                     nb;
	logic [ttbd_pkg::MaxBytes-1:0][7:0] byt;
	logic [ttbd_pkg::CountWidth:0]  count_sum;
	logic [ttbd_pkg::CountWidth:0]  probe;
	logic [1:0]                     n_emit;
	logic [2:0]                     st;

	assign c = in_data.in_char;
	assign last = in_data.in_last;
	assign hx = ttbd_pkg::hex_lookup(c);
	assign bx = ttbd_pkg::b64_lookup(c);

	// Classify the character and advance the string state.
	always_comb begin
		phase_d = phase_q;
		base_d = base_q;
		pos_d = pos_q;
		bits_d = bits_q;
		kinds_d = kinds_q;
		open_d = open_q;
		seen_d = seen_q;
		uok_d = uok_q;
		err_d = err_q;
		use_base = base_q;
		run_data = 1'b0;
		blank = 1'b0;
		skip = 1'b0;
		p = pos_q;
		kind = KDigit;
		val = '0;
		nb = '0;
		byt = '0;

		if (err_q == ttbd_pkg::StOk) begin
			case (phase_q)
				PhFirst: begin
					if (cfg.base_mode == ttbd_pkg::ModeAuto) begin
						if (last) begin
							err_d = ttbd_pkg::StShort;
						end else if (c != ttbd_pkg::ChZero) begin
							err_d = ttbd_pkg::StNoPrefix;
						end else begin
							phase_d = PhLetter;
						end
					end else begin
						base_d = cfg.base_mode;
						use_base = cfg.base_mode;
						phase_d = PhData;
						run_data = 1'b1;
					end
				end
				PhLetter: begin
					if (c == 8'h78 || c == 8'h58) begin
						base_d = ttbd_pkg::ModeHex;
					end else if (c == 8'h73 || c == 8'h53) begin
						base_d = ttbd_pkg::ModeB64;
					end else if (c == 8'h74 || c == 8'h54) begin
						base_d = ttbd_pkg::ModeText;
					end else begin
						err_d = ttbd_pkg::StBadPrefix;
					end
					phase_d = PhData;
				end
				default: begin
					run_data = 1'b1;
				end
			endcase
		end

		if (run_data) begin
			if (use_base == ttbd_pkg::ModeText) begin
				nb = 2'd1;
				byt[0] = c;
			end else begin
				blank = use_base == ttbd_pkg::ModeB64 && cfg.ignore_blanks &&
					(c == ttbd_pkg::ChSpace || c == ttbd_pkg::ChTab);
				// Between groups: optional underscore, skipped blanks, or a new group.
				if (!open_q) begin
					uok_d = 1'b0;
					p = 2'd0;
					if (uok_q && c == ttbd_pkg::ChUnder && !last) begin
						skip = 1'b1;
					end else if (blank && seen_q) begin
						skip = 1'b1;
					end else begin
						open_d = 1'b1;
						pos_d = 2'd0;
						bits_d = '0;
						kinds_d = '0;
					end
				end
				if (!skip && !blank) begin
					if (use_base == ttbd_pkg::ModeHex) begin
						kind = hx[4] ? KDigit : KBad;
						val = {2'b00, hx[3:0]};
					end else if (bx[6]) begin
						kind = KDigit;
						val = bx[5:0];
					end else if (c == ttbd_pkg::ChPad) begin
						kind = KPad;
					end else begin
						kind = KBad;
					end
					if ((use_base == ttbd_pkg::ModeHex && p == 2'd1) || p == 2'd3) begin
						// Group complete: decode the staged characters with this one.
						open_d = 1'b0;
						seen_d = 1'b1;
						pos_d = 2'd0;
						bits_d = '0;
						kinds_d = '0;
						if (kinds_q[0] != KDigit || (use_base == ttbd_pkg::ModeHex ?
							kind != KDigit : kinds_q[1] != KDigit)) begin
							err_d = ttbd_pkg::StBadChar;
						end else if (use_base == ttbd_pkg::ModeHex) begin
							nb = 2'd1;
							byt[0] = {bits_q[0][3:0], val[3:0]};
							uok_d = 1'b1;
						end else begin
							byt[0] = {bits_q[0], bits_q[1][5:4]};
							byt[1] = {bits_q[1][3:0], bits_q[2][5:2]};
							byt[2] = {bits_q[2][1:0], val};
							if (kinds_q[2] != KDigit) begin
								if (kinds_q[2] == KPad && kind == KPad) begin
									if (bits_q[1][3:0] != 4'd0) begin
										err_d = ttbd_pkg::StBadPad;
									end else begin
										nb = 2'd1;
									end
								end else begin
									err_d = ttbd_pkg::StBadChar;
								end
							end else if (kind != KDigit) begin
								if (kind == KPad) begin
									if (bits_q[2][1:0] != 2'd0) begin
										err_d = ttbd_pkg::StBadPad;
									end else begin
										nb = 2'd2;
									end
								end else begin
									err_d = ttbd_pkg::StBadChar;
								end
							end else begin
								nb = 2'd3;
							end
						end
					end else begin
						bits_d[p] = val;
						kinds_d[p] = kind;
						pos_d = p + 2'd1;
					end
				end
			end
		end
	end

	// Saturating byte count and the number of bytes within capacity.
	always_comb begin
		count_sum = {1'b0, count_q} + {{(ttbd_pkg::CountWidth - 1){1'b0}}, nb};
		count_d = (count_sum >= {1'b0, ttbd_pkg::CountMax}) ? ttbd_pkg::CountMax :
			count_sum[ttbd_pkg::CountWidth-1:0];
		n_emit = '0;
		for (int k = 0; k < ttbd_pkg::MaxBytes; k++) begin
			probe = {1'b0, count_q} + (ttbd_pkg::CountWidth + 1)'(k);
			if (k < int'(nb) && probe < {1'b0, cfg.out_capacity} &&
				probe < {1'b0, ttbd_pkg::CountMax}) begin
				n_emit = n_emit + 2'd1;
			end
		end
	end

	// End-of-string status.
	always_comb begin
		if (err_d != ttbd_pkg::StOk) begin
			st = err_d;
		end else if (open_d) begin
			st = ttbd_pkg::StTruncated;
		end else if (count_d == '0) begin
			st = ttbd_pkg::StNoData;
		end else begin
			st = ttbd_pkg::StOk;
		end
	end

	// Entry handed to the back end; characters with no result push nothing.
	assign accept = push && q_ready;
	assign q_valid = push && (n_emit != 2'd0 || last);
	always_comb begin
		q_entry.bytes = byt;
		q_entry.n_data = n_emit;
		q_entry.base_count = count_q;
		q_entry.has_status = last;
		q_entry.status = st;
		q_entry.status_count = count_d;
	end

	// String state; the last character returns it to its reset values.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PhFirst;
			base_q <= '0;
			pos_q <= '0;
			bits_q <= '0;
			kinds_q <= '0;
			open_q <= 1'b0;
			seen_q <= 1'b0;
			uok_q <= 1'b0;
			err_q <= ttbd_pkg::StOk;
			count_q <= '0;
		end else if (accept) begin
			if (last) begin
				phase_q <= PhFirst;
				base_q <= '0;
				pos_q <= '0;
				bits_q <= '0;
				kinds_q <= '0;
				open_q <= 1'b0;
				seen_q <= 1'b0;
				uok_q <= 1'b0;
				err_q <= ttbd_pkg::StOk;
				count_q <= '0;
			end else begin
				phase_q <= phase_d;
				base_q <= base_d;
				pos_q <= pos_d;
				bits_q <= bits_d;
				kinds_q <= kinds_d;
				open_q <= open_d;
				seen_q <= seen_d;
				uok_q <= uok_d;
				err_q <= err_d;
				count_q <= count_d;
			end
		end
	end

endmodule

// ===== rtl/core/ttbd_back.sv =====
`timescale 1ns / 1ps

module ttbd_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  ttbd_pkg::entry_t    q_entry,
	output logic                q_ready,
	output logic                empty,
	input  logic                pop,
	output ttbd_pkg::out_item_t out_data
);

	ttbd_pkg::entry_t                  ent_q [ttbd_pkg::QueueDepth];
	logic [ttbd_pkg::QueuePtrWidth-1:0] wr_ptr_q;
	logic [ttbd_pkg::QueuePtrWidth-1:0] rd_ptr_q;
	logic [ttbd_pkg::QueuePtrWidth:0]   cnt_q;
	logic [1:0]                        idx_q;

	ttbd_pkg::entry_t head;
	logic [2:0]       total;
	logic             is_last;
	logic             is_data;
	logic             wr;
	logic             rd;
	logic             rd_entry;

	assign q_ready = cnt_q != ttbd_pkg::QueueDepth[ttbd_pkg::QueuePtrWidth:0];
	assign empty = cnt_q == '0;
	assign wr = q_valid && q_ready;
	assign rd = pop && !empty;

	// Result selection inside the head entry.
	assign head = ent_q[rd_ptr_q];
	assign total = {1'b0, head.n_data} + {2'b00, head.has_status};
	assign is_last = ({1'b0, idx_q} + 3'd1) == total;
	assign is_data = idx_q < head.n_data;
	assign rd_entry = rd && is_last;

	always_comb begin
		out_data.out_last = is_last;
		if (is_data) begin
			out_data.out_kind = ttbd_pkg::KindData;
			out_data.out_byte = head.bytes[idx_q];
			out_data.status = ttbd_pkg::StOk;
			out_data.byte_count = head.base_count +
				{{(ttbd_pkg::CountWidth - 2){1'b0}}, idx_q} + 1'b1;
		end else begin
			out_data.out_kind = ttbd_pkg::KindStatus;
			out_data.out_byte = '0;
			out_data.status = head.status;
			out_data.byte_count = head.status_count;
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (wr) begin
			ent_q[wr_ptr_q] <= q_entry;
		end
	end

	// Queue pointers and the result index within the head entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
			idx_q <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd) begin
				if (is_last) begin
					rd_ptr_q <= rd_ptr_q + 1'b1;
					idx_q <= '0;
				end else begin
					idx_q <= idx_q + 2'd1;
				end
			end
			if (wr && !rd_entry) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!wr && rd_entry) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/text_to_binary_decoder_core.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Transfer when       Payload
// input     in         push && !full       in_data  (in_char, in_last)
// result    out        pop && !empty       out_data (out_kind, out_byte, status,
//                                                    byte_count, out_last)
// config    in         cfg_we              cfg_index, cfg_data
//
// One character is taken every cycle while the entry queue (four entries) has room.
// An accepted character with results writes one entry into the queue; each result
// leaves as one transfer, so a base64 group with three bytes and status gives four.
// Reset clears the string state, the queue and the registers to their defaults.
// full rises only when four entries wait on a stalled result side.
module text_to_binary_decoder_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	output logic                               full,
	input  ttbd_pkg::in_item_t                 in_data,
	output logic                               empty,
	input  logic                               pop,
	output ttbd_pkg::out_item_t                out_data,
	input  logic                               cfg_we,
	input  logic [1:0]                         cfg_index,
	input  logic [ttbd_pkg::CountWidth-1:0]    cfg_data
);

	ttbd_pkg::cfg_t   cfg_q;
	ttbd_pkg::entry_t q_entry;
	logic             q_valid;
	logic             q_ready;
	logic             accept;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base_mode <= ttbd_pkg::ModeAuto;
			cfg_q.ignore_blanks <= 1'b0;
			cfg_q.out_capacity <= ttbd_pkg::CountMax;
		end else if (cfg_we) begin
			case (cfg_index)
				ttbd_pkg::RegBaseMode: cfg_q.base_mode <= cfg_data[1:0];
				ttbd_pkg::RegIgnoreBlanks: cfg_q.ignore_blanks <= cfg_data[0];
				ttbd_pkg::RegOutCapacity: cfg_q.out_capacity <= cfg_data;
				default: ;
			endcase
		end
	end

	assign full = !q_ready;

	ttbd_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.push    (push),
		.in_data (in_data),
		.q_ready (q_ready),
		.q_valid (q_valid),
		.q_entry (q_entry),
		.accept  (accept)
	);

	ttbd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid && accept),
		.q_entry  (q_entry),
		.q_ready  (q_ready),
		.empty    (empty),
		.pop      (pop),
		.out_data (out_data)
	);

endmodule

// ===== rtl/core/ttbd_checker.sv =====
`timescale 1ns / 1ps

module ttbd_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                push,
	input logic                full,
	input logic                empty,
	input logic                pop,
	input ttbd_pkg::out_item_t out_data
);

	// A status result always closes the results of its character.
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && out_data.out_kind == ttbd_pkg::KindStatus) |-> out_data.out_last)
		else $error("status result without out_last");

	// Within one character, a data byte is followed by a status or by the next count.
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && out_data.out_kind == ttbd_pkg::KindData && !out_data.out_last)
		|=> (!empty && (out_data.out_kind == ttbd_pkg::KindStatus ||
			out_data.byte_count == $past(out_data.byte_count) + 1'b1)))
		else $error("byte count did not advance by one");

	// Results appear only after an input transfer.
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		(empty && !(push && !full)) |=> empty)
		else $error("result appeared without an input transfer");

	// A stalled result holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(out_data)))
		else $error("stalled result changed");

endmodule

bind text_to_binary_decoder_core ttbd_checker u_ttbd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.push     (push),
	.full     (full),
	.empty    (empty),
	.pop      (pop),
	.out_data (out_data)
);

// ===== tb/sv/tb_text_to_binary_decoder_core.sv =====
`timescale 1ns / 1ps

module tb_text_to_binary_decoder_core;
	import ttbd_pkg::*;

	localparam int NumPhases = 9;
	localparam int PhaseChars = 39;
	localparam int SettleCycles = 8;
	localparam int StuckLimit = 1000;
	localparam logic [1:0] RegUnused = 2'd3;

	// Per-character classification inside an open group.
	typedef enum logic [1:0] {KIND_DIGIT, KIND_PAD, KIND_BAD} char_kind_e;
	// Where the decoder stands in the current string.
	typedef enum logic [1:0] {PH_FIRST, PH_LETTER, PH_DATA} prefix_phase_e;

	// Predicts the decoded bytes and string status, and checks each result transfer.
	class decode_scoreboard;
		logic [1:0] mode_r;
		bit blanks_r;
		logic [CountWidth-1:0] cap_r;

		prefix_phase_e phase;
		logic [1:0] base;
		int grp_pos;
		logic [23:0] grp_bits;
		logic [7:0] grp_kinds;
		bit grp_open;
		bit grp_seen;
		bit under_ok;
		logic [2:0] held_err;
		logic [CountWidth-1:0] byte_total;

		out_item_t decoded_q[$];
		out_item_t step_q[$];
		int errors;
		int checked_bytes;
		int checked_status;
		int status_hits[8];

		function new();
			set_config(ModeAuto, 1'b0, CountMax);
			clear_string();
			errors = 0;
			checked_bytes = 0;
			checked_status = 0;
			foreach (status_hits[i]) status_hits[i] = 0;
		endfunction

		function void set_config(logic [1:0] mode, bit blanks, logic [CountWidth-1:0] cap);
			mode_r = mode;
			blanks_r = blanks;
			cap_r = cap;
		endfunction

		function void clear_string();
			phase = PH_FIRST;
			base = ModeAuto;
			grp_pos = 0;
			grp_bits = '0;
			grp_kinds = '0;
			grp_open = 1'b0;
			grp_seen = 1'b0;
			under_ok = 1'b0;
			held_err = StOk;
			byte_total = '0;
		endfunction

		function int pending();
			return decoded_q.size();
		endfunction

		function int hex_value(logic [7:0] c);
			if (c >= "0" && c <= "9") return int'(c - "0");
			if (c >= "a" && c <= "f") return int'(c - "a") + 10;
			if (c >= "A" && c <= "F") return int'(c - "A") + 10;
			return -1;
		endfunction

		function int b64_value(logic [7:0] c);
			if (c >= "A" && c <= "Z") return int'(c - "A");
			if (c >= "a" && c <= "z") return int'(c - "a") + 26;
			if (c >= "0" && c <= "9") return int'(c - "0") + 52;
			if (c == ChPlus) return 62;
			if (c == ChSlash) return 63;
			return -1;
		endfunction

		// The count always advances (saturating); the byte leaves only below capacity.
		function void emit_byte(logic [7:0] b);
			logic [CountWidth-1:0] prior;
			out_item_t r;
			prior = byte_total;
			if (byte_total != CountMax) byte_total++;
			if (prior < cap_r && prior != CountMax && step_q.size() < 4) begin
				r.out_kind = KindData;
				r.out_byte = b;
				r.status = StOk;
				r.byte_count = byte_total;
				r.out_last = 1'b0;
				step_q.push_back(r);
			end
		endfunction

		// Turns a complete group into bytes or an error.
		function void decode_group();
			logic [5:0] v0, v1, v2, v3;
			logic [1:0] k0, k1, k2, k3;
			logic [7:0] b0, b1, b2;
			v0 = grp_bits[5:0];
			v1 = grp_bits[11:6];
			v2 = grp_bits[17:12];
			v3 = grp_bits[23:18];
			k0 = grp_kinds[1:0];
			k1 = grp_kinds[3:2];
			k2 = grp_kinds[5:4];
			k3 = grp_kinds[7:6];
			if (k0 != KIND_DIGIT || k1 != KIND_DIGIT) begin
				held_err = StBadChar;
				return;
			end
			if (base == ModeHex) begin
				emit_byte({v0[3:0], v1[3:0]});
				under_ok = 1'b1;
				return;
			end
			b0 = {v0, v1[5:4]};
			if (k2 != KIND_DIGIT) begin
				if (k2 == KIND_PAD && k3 == KIND_PAD) begin
					if (v1[3:0] != 4'd0) held_err = StBadPad;
					else emit_byte(b0);
				end else begin
					held_err = StBadChar;
				end
				return;
			end
			b1 = {v1[3:0], v2[5:2]};
			if (k3 != KIND_DIGIT) begin
				if (k3 == KIND_PAD) begin
					if (v2[1:0] != 2'd0) begin
						held_err = StBadPad;
					end else begin
						emit_byte(b0);
						emit_byte(b1);
					end
				end else begin
					held_err = StBadChar;
				end
				return;
			end
			b2 = {v2[1:0], v3};
			emit_byte(b0);
			emit_byte(b1);
			emit_byte(b2);
		endfunction

		// Handles one character once the encoding is known.
		function void take_char(logic [7:0] c, bit last);
			bit blank;
			int d;
			logic [5:0] v;
			logic [1:0] k;
			if (base == ModeText) begin
				emit_byte(c);
				return;
			end
			blank = base == ModeB64 && blanks_r && (c == ChSpace || c == ChTab);
			if (!grp_open) begin
				// A single underscore may follow a complete hex pair.
				if (under_ok && c == ChUnder && !last) begin
					under_ok = 1'b0;
					return;
				end
				under_ok = 1'b0;
				if (blank && grp_seen) return;
				grp_open = 1'b1;
				grp_pos = 0;
				grp_bits = '0;
				grp_kinds = '0;
			end
			if (blank) return;
			d = (base == ModeHex) ? hex_value(c) : b64_value(c);
			if (d >= 0) begin
				k = KIND_DIGIT;
				v = d[5:0];
			end else if (base == ModeB64 && c == ChPad) begin
				k = KIND_PAD;
				v = '0;
			end else begin
				k = KIND_BAD;
				v = '0;
			end
			grp_bits[6*grp_pos +: 6] = v;
			grp_kinds[2*grp_pos +: 2] = k;
			grp_pos++;
			if (grp_pos >= ((base == ModeHex) ? 2 : 4)) begin
				grp_open = 1'b0;
				grp_seen = 1'b1;
				grp_pos = 0;
				decode_group();
				grp_bits = '0;
				grp_kinds = '0;
			end
		endfunction

		// Notes an accepted input transfer; returns 1 unless the character was ignored.
		function bit note_char(in_item_t it);
			bit live;
			out_item_t r;
			live = (held_err == StOk) || it.in_last;
			step_q.delete();
			if (held_err == StOk) begin
				case (phase)
					PH_FIRST: begin
						if (mode_r == ModeAuto) begin
							if (it.in_last) held_err = StShort;
							else if (it.in_char != ChZero) held_err = StNoPrefix;
							else phase = PH_LETTER;
						end else begin
							base = mode_r;
							phase = PH_DATA;
							take_char(it.in_char, it.in_last);
						end
					end
					PH_LETTER: begin
						if (it.in_char == "x" || it.in_char == "X") base = ModeHex;
						else if (it.in_char == "s" || it.in_char == "S") base = ModeB64;
						else if (it.in_char == "t" || it.in_char == "T") base = ModeText;
						else held_err = StBadPrefix;
						phase = PH_DATA;
					end
					default: take_char(it.in_char, it.in_last);
				endcase
			end
			// The last character closes the string with a status result.
			if (it.in_last) begin
				r.out_kind = KindStatus;
				r.out_byte = '0;
				if (held_err != StOk) r.status = held_err;
				else if (grp_open) r.status = StTruncated;
				else if (byte_total == '0) r.status = StNoData;
				else r.status = StOk;
				r.byte_count = byte_total;
				r.out_last = 1'b0;
				step_q.push_back(r);
				clear_string();
			end
			if (step_q.size() > 0) begin
				r = step_q[step_q.size()-1];
				r.out_last = 1'b1;
				step_q[step_q.size()-1] = r;
			end
			foreach (step_q[i]) decoded_q.push_back(step_q[i]);
			return live;
		endfunction

		task report(string msg);
			errors++;
			if (errors <= 50) $display("MISMATCH at %0t: %s", $realtime, msg);
		endtask

		// Compares one result transfer with the oldest expected result.
		task check_result(out_item_t got);
			out_item_t want;
			if (decoded_q.size() == 0) begin
				report($sformatf("unexpected result kind %0d byte %02h status %0d count %0d",
					got.out_kind, got.out_byte, got.status, got.byte_count));
				return;
			end
			want = decoded_q.pop_front();
			if (want.out_kind == KindStatus) begin
				checked_status++;
				status_hits[want.status]++;
			end else begin
				checked_bytes++;
			end
			if (got.out_kind !== want.out_kind)
				report($sformatf("out_kind %0d, expected %0d", got.out_kind, want.out_kind));
			if (got.out_byte !== want.out_byte)
				report($sformatf("out_byte %02h, expected %02h", got.out_byte, want.out_byte));
			if (got.status !== want.status)
				report($sformatf("status %0d, expected %0d", got.status, want.status));
			if (got.byte_count !== want.byte_count)
				report($sformatf("byte_count %0d, expected %0d", got.byte_count, want.byte_count));
			if (got.out_last !== want.out_last)
				report($sformatf("out_last %0d, expected %0d", got.out_last, want.out_last));
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic push;
	logic full;
	in_item_t in_data;
	logic empty;
	logic pop;
	out_item_t out_data;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [CountWidth-1:0] cfg_data;

	decode_scoreboard sb;
	logic [7:0] text_q[$];
	string hex_alpha = "0123456789abcdefABCDEF";
	string b64_alpha = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
	string prefix_alpha = "xXsStT";
	bit gaps_on;
	int burst_left;
	int sent_chars;
	int live_chars;
	int sent_strings;
	int settings_used;
	int stuck_cycles;

	text_to_binary_decoder_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.in_data   (in_data),
		.empty     (empty),
		.pop       (pop),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function logic [7:0] pick_blank();
		return ($urandom_range(0, 1) == 0) ? ChSpace : ChTab;
	endfunction

	// Characters that tend to hit the special cases.
	function logic [7:0] pick_odd();
		case ($urandom_range(0, 9))
			0: return 8'h00;
			1: return ChPad;
			2: return ChUnder;
			3: return ChSpace;
			4: return ChTab;
			5: return ChZero;
			default: return 8'($urandom);
		endcase
	endfunction

	function void add_hex();
		int pairs;
		pairs = $urandom_range(0, 5);
		for (int p = 0; p < pairs; p++) begin
			text_q.push_back(hex_alpha[$urandom_range(0, 21)]);
			text_q.push_back(hex_alpha[$urandom_range(0, 21)]);
			if (p < pairs - 1 && $urandom_range(0, 2) == 0) text_q.push_back(ChUnder);
		end
	endfunction

	// Base64 groups, with padding whose leftover bits are usually zero.
	function void add_b64(bit blanks);
		int groups;
		int pad;
		logic [5:0] v[4];
		if (blanks && $urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 3)) text_q.push_back(pick_blank());
			return;
		end
		groups = $urandom_range(1, 3);
		for (int g = 0; g < groups; g++) begin
			pad = 0;
			if ((g == groups - 1 && $urandom_range(0, 2) == 0) || $urandom_range(0, 11) == 0)
				pad = $urandom_range(1, 2);
			for (int i = 0; i < 4; i++) v[i] = 6'($urandom);
			if (pad == 1 && $urandom_range(0, 5) != 0) v[1][3:0] = 4'd0;
			if (pad == 2 && $urandom_range(0, 5) != 0) v[2][1:0] = 2'd0;
			for (int i = 0; i < 4; i++) begin
				if ((blanks && $urandom_range(0, 3) == 0) || $urandom_range(0, 39) == 0)
					text_q.push_back(pick_blank());
				if ((pad == 1 && i >= 2) || (pad == 2 && i == 3)) text_q.push_back(ChPad);
				else text_q.push_back(b64_alpha[v[i]]);
			end
		end
		if (blanks && $urandom_range(0, 3) == 0) text_q.push_back(pick_blank());
	endfunction

	function void add_text();
		repeat ($urandom_range(1, 8)) text_q.push_back(8'($urandom));
	endfunction

	// Builds one string: mostly well formed, some mutated, truncated or pure noise.
	function void make_string(logic [1:0] mode, bit blanks);
		logic [1:0] enc;
		int idx;
		text_q.delete();
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 10)) text_q.push_back(pick_odd());
		end else begin
			enc = mode;
			if (mode == ModeAuto) begin
				enc = 2'($urandom_range(1, 3));
				idx = 2 * int'(enc) - 2 + $urandom_range(0, 1);
				text_q.push_back(ChZero);
				text_q.push_back(prefix_alpha[idx]);
			end
			case (enc)
				ModeHex: add_hex();
				ModeB64: add_b64(blanks);
				default: add_text();
			endcase
			if ($urandom_range(0, 4) == 0 && text_q.size() > 0)
				text_q[$urandom_range(0, text_q.size() - 1)] = pick_odd();
			if ($urandom_range(0, 9) == 0 && text_q.size() > 1) void'(text_q.pop_back());
			if ($urandom_range(0, 14) == 0) text_q.push_back(ChUnder);
		end
		if (text_q.size() == 0) text_q.push_back(8'($urandom));
	endfunction

	// Sends one character, in bursts with random gaps, and waits for its transfer.
	task automatic send_char(input logic [7:0] c, input bit last);
		in_item_t it;
		int gap;
		if (gaps_on && burst_left <= 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		it.in_char = c;
		it.in_last = last;
		push <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (full);
		if (sb.note_char(it)) live_chars++;
		sent_chars++;
		burst_left--;
	endtask

	task automatic send_text();
		foreach (text_q[i]) send_char(text_q[i], i == text_q.size() - 1);
		sent_strings++;
	endtask

	task automatic send_literal(input string s);
		text_q.delete();
		for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
		send_text();
	endtask

	// Drains all expected results, then lets the pipeline go quiet.
	task automatic settle();
		push <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	// Writes all registers (and the unused index) while the decoder is idle.
	task automatic write_regs(input logic [1:0] mode, input bit blanks,
			input logic [CountWidth-1:0] cap);
		logic [CountWidth-1:0] junk;
		junk = CountWidth'($urandom);
		cfg_we <= 1'b1;
		cfg_index <= RegBaseMode;
		cfg_data <= {junk[CountWidth-1:2], mode};
		@(posedge clk);
		cfg_index <= RegIgnoreBlanks;
		cfg_data <= {junk[CountWidth-1:1], blanks};
		@(posedge clk);
		cfg_index <= RegOutCapacity;
		cfg_data <= cap;
		@(posedge clk);
		cfg_index <= RegUnused;
		cfg_data <= ~junk;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_config(mode, blanks, cap);
		settings_used++;
	endtask

	// Result side: checks each transfer and stalls on its own shifting pattern.
	initial begin
		int rx_mode;
		int rx_left;
		int rx_hold;
		bit ready;
		rx_mode = 0;
		rx_left = 0;
		rx_hold = 0;
		pop = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (pop && !empty) sb.check_result(out_data);
			if (rx_left == 0) begin
				rx_mode = $urandom_range(0, 3);
				rx_left = $urandom_range(20, 120);
			end
			rx_left--;
			case (rx_mode)
				0: ready = 1'b1;
				1: ready = $urandom_range(0, 3) != 0;
				2: ready = $urandom_range(0, 3) == 0;
				default: begin
					if (rx_hold > 0) begin
						ready = 1'b0;
						rx_hold--;
					end else begin
						ready = 1'b1;
						if ($urandom_range(0, 7) == 0) rx_hold = $urandom_range(5, 30);
					end
				end
			endcase
			pop <= ready;
		end
	end

	// Watchdog: ends the run when no transfer happens for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty)) begin
				stuck_cycles = 0;
			end else begin
				stuck_cycles++;
				if (stuck_cycles >= StuckLimit) begin
					$display("Timeout: no transfer for %0d cycles", StuckLimit);
					$display("CHECKS FAILED");
					$finish;
				end
			end
		end
	end

	// Stimulus: reset, directed strings, then random phases.
	initial begin
		logic [1:0] mode;
		bit blanks;
		logic [CountWidth-1:0] cap;
		int target;
		arst_n = 1'b0;
		push = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_index = RegBaseMode;
		cfg_data = '0;
		stuck_cycles = 0;
		gaps_on = 1'b1;
		burst_left = 0;
		sent_chars = 0;
		live_chars = 0;
		sent_strings = 0;
		settings_used = 0;
		sb = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under the reset settings: the prefix cases, an underscore,
		// zero-bit padding and an underscore closing the string.
		send_literal("0");
		send_literal("ab");
		send_literal("0q");
		send_literal("0x");
		send_literal("0xfF_A9");
		send_literal("0sQQ==");
		send_literal("0X12_");
		settle();

		// Random phases, each under its own register setting.
		for (int p = 0; p < NumPhases; p++) begin
			case (p)
				0: begin mode = ModeAuto; blanks = 1'b0; cap = CountMax; end
				1: begin mode = ModeHex; blanks = 1'b0; cap = '0; end
				2: begin mode = ModeB64; blanks = 1'b1; cap = CountMax; end
				3: begin mode = ModeText; blanks = 1'b0; cap = CountWidth'(1); end
				4: begin mode = ModeAuto; blanks = 1'b1; cap = CountWidth'(3); end
				5: begin mode = ModeB64; blanks = 1'b0; cap = CountMax; end
				6: begin mode = ModeHex; blanks = 1'b1; cap = CountWidth'(7); end
				default: begin
					mode = 2'($urandom_range(0, 3));
					blanks = 1'($urandom_range(0, 1));
					cap = ($urandom_range(0, 1) == 0) ? CountMax :
						CountWidth'($urandom_range(0, 20));
				end
			endcase
			write_regs(mode, blanks, cap);
			target = sent_chars + PhaseChars;
			while (sent_chars < target) begin
				make_string(mode, blanks);
				send_text();
			end
			settle();
		end

		if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));
		$display("Covered %0d characters (%0d decoded) in %0d strings under %0d settings.",
			sent_chars, live_chars, sent_strings, settings_used);
		$display("Checked %0d bytes, %0d statuses: ok %0d short %0d noprefix %0d badprefix %0d",
			sb.checked_bytes, sb.checked_status, sb.status_hits[StOk],
			sb.status_hits[StShort], sb.status_hits[StNoPrefix], sb.status_hits[StBadPrefix]);
		$display("  badchar %0d badpad %0d truncated %0d nodata %0d",
			sb.status_hits[StBadChar], sb.status_hits[StBadPad],
			sb.status_hits[StTruncated], sb.status_hits[StNoData]);
		if (sb.errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
